@@ rtl/core/rgtc_pkg.sv @@
// Shared types, codes and constants for the remote-gated transport control.
`default_nettype none
package rgtc_pkg;

    // Item function codes (s_tuser)
    localparam logic [1:0] FUNC_SCAN     = 2'd0;
    localparam logic [1:0] FUNC_EVENT    = 2'd1;
    localparam logic [1:0] FUNC_LOAD     = 2'd2;
    localparam logic [1:0] FUNC_REEVAL   = 2'd3;

    // Transport mode codes; codes above MODE_RECORDING are kept but act like other
    localparam logic [2:0] MODE_OTHER      = 3'd0;
    localparam logic [2:0] MODE_PLAY_STBY  = 3'd1;
    localparam logic [2:0] MODE_PLAYING    = 3'd2;
    localparam logic [2:0] MODE_REC_STBY   = 3'd3;
    localparam logic [2:0] MODE_RECORDING  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_ON_DELAY  = 1'b0;
    localparam logic CFG_OFF_DELAY = 1'b1;

    localparam int DELAY_W = 16;
    localparam int TIME_W  = 32;
    localparam logic [DELAY_W-1:0] ON_DELAY_RESET  = 16'd50;
    localparam logic [DELAY_W-1:0] OFF_DELAY_RESET = 16'd500;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 80;

    // Transport state touched by the play/record gate
    typedef struct packed {
        logic [2:0]        mode;
        logic              play_permit;
        logic              rec_permit;
        logic              play_hold;
        logic              rec_hold;
        logic              play_begun;
        logic [TIME_W-1:0] base_ms;
        logic [TIME_W-1:0] resume_ms;
    } gate_state_t;

    // Gate result: updated state and the two pulses
    typedef struct packed {
        gate_state_t st;
        logic        stop_rec;
        logic        refresh;
    } gate_out_t;

    // Result item, laid out as m_tdata from the lowest bit up (last member lowest)
    typedef struct packed {
        logic [3:0]        pad;
        logic              refresh_pulse;
        logic              stop_rec_pulse;
        logic [TIME_W-1:0] segment_start_ms;
        logic [TIME_W-1:0] played_ms;
        logic              override_now;
        logic              play_begun;
        logic              rec_hold;
        logic              play_hold;
        logic              rec_permit;
        logic              play_permit;
        logic [2:0]        mode;
        logic              remote_en;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/core/rgtc_gate.sv @@
// Play/record permission gate: pure combinational update of the transport state.
`default_nettype none
module rgtc_gate (
    input  wire rgtc_pkg::gate_state_t   st_in,
    input  wire logic                    go,
    input  wire logic                    timing_valid,
    input  wire logic [rgtc_pkg::TIME_W-1:0] now_ms,
    output rgtc_pkg::gate_out_t          gate_out
);

    logic play_mode;
    logic rec_mode;

    assign play_mode = (st_in.mode == rgtc_pkg::MODE_PLAY_STBY) ||
                       (st_in.mode == rgtc_pkg::MODE_PLAYING);
    assign rec_mode  = (st_in.mode == rgtc_pkg::MODE_REC_STBY) ||
                       (st_in.mode == rgtc_pkg::MODE_RECORDING);

    always_comb begin
        gate_out          = '0;
        gate_out.st       = st_in;
        gate_out.stop_rec = 1'b0;
        gate_out.refresh  = 1'b0;

        // Play side: run or pause, accumulate elapsed time on pause
        if (play_mode) begin
            if (go) begin
                if (st_in.play_hold) begin
                    gate_out.st.resume_ms = now_ms;
                end
                gate_out.st.play_permit = 1'b1;
                gate_out.st.play_begun  = 1'b1;
                gate_out.st.play_hold   = 1'b0;
                gate_out.st.mode        = rgtc_pkg::MODE_PLAYING;
            end else begin
                if (!st_in.play_hold && timing_valid) begin
                    gate_out.st.base_ms = st_in.base_ms + (now_ms - st_in.resume_ms);
                end
                gate_out.st.play_permit = 1'b0;
                gate_out.st.play_hold   = 1'b1;
                if (st_in.mode == rgtc_pkg::MODE_PLAYING) begin
                    gate_out.st.mode = rgtc_pkg::MODE_PLAY_STBY;
                    gate_out.refresh = 1'b1;
                end
            end
        end

        // Record side: run, or pause and ask for a stop while recording
        if (rec_mode) begin
            if (go) begin
                gate_out.st.rec_permit = 1'b1;
                gate_out.st.rec_hold   = 1'b0;
                gate_out.st.mode       = rgtc_pkg::MODE_RECORDING;
            end else begin
                if (st_in.mode == rgtc_pkg::MODE_RECORDING) begin
                    gate_out.stop_rec = 1'b1;
                end
                gate_out.st.rec_permit = 1'b0;
                gate_out.st.rec_hold   = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/rgtc_ctrl.sv @@
// Debounce, item decode and state registers; builds one result per accepted item.
`default_nettype none
module rgtc_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_index,
    input  wire logic [rgtc_pkg::DELAY_W-1:0] cfg_wdata,
    input  wire logic                         item_accept,
    input  wire logic [1:0]                   func,
    input  wire logic [rgtc_pkg::TIME_W-1:0]  now_ms,
    input  wire logic                         pin_level,
    input  wire logic                         event_on,
    input  wire logic [2:0]                   new_mode,
    input  wire logic                         new_override,
    input  wire logic                         new_time_valid,
    output rgtc_pkg::result_t                 result
);

    logic [rgtc_pkg::DELAY_W-1:0] on_delay_reg;
    logic [rgtc_pkg::DELAY_W-1:0] off_delay_reg;

    logic                        deb_level_reg, deb_level_next;
    logic                        motor_reg, motor_next;
    logic                        armed_reg, armed_next;
    logic [rgtc_pkg::TIME_W-1:0] since_reg, since_next;
    logic                        override_reg, override_next;
    logic                        tvalid_reg, tvalid_next;
    rgtc_pkg::gate_state_t       gst_reg, gst_next;

    rgtc_pkg::gate_state_t       gate_in;
    rgtc_pkg::gate_out_t         gate_res;
    logic                        run_gate;
    logic                        target;
    logic [rgtc_pkg::TIME_W-1:0] elapsed;
    logic [rgtc_pkg::DELAY_W-1:0] need;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_delay_reg  <= rgtc_pkg::ON_DELAY_RESET;
            off_delay_reg <= rgtc_pkg::OFF_DELAY_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == rgtc_pkg::CFG_ON_DELAY) begin
                on_delay_reg <= cfg_wdata;
            end else begin
                off_delay_reg <= cfg_wdata;
            end
        end
    end

    assign target  = !pin_level;
    assign elapsed = now_ms - since_reg;
    assign need    = target ? on_delay_reg : off_delay_reg;

    // Decode the item: debounce, forced event, context load or re-evaluation
    always_comb begin
        deb_level_next = deb_level_reg;
        motor_next     = motor_reg;
        armed_next     = armed_reg;
        since_next     = since_reg;
        override_next  = override_reg;
        tvalid_next    = tvalid_reg;
        gate_in        = gst_reg;
        run_gate       = 1'b0;
        case (func)
            rgtc_pkg::FUNC_SCAN: begin
                if (target == deb_level_reg) begin
                    armed_next = 1'b0;
                end else if (!armed_reg) begin
                    armed_next = 1'b1;
                    since_next = now_ms;
                end else if (elapsed > {{(rgtc_pkg::TIME_W-rgtc_pkg::DELAY_W){1'b0}}, need}) begin
                    deb_level_next = target;
                    armed_next     = 1'b0;
                    motor_next     = target;
                    if (!target) begin
                        override_next = 1'b0;
                    end
                    run_gate = 1'b1;
                end
            end
            rgtc_pkg::FUNC_EVENT: begin
                motor_next = event_on;
                if (!event_on) begin
                    override_next = 1'b0;
                end
                run_gate = 1'b1;
            end
            rgtc_pkg::FUNC_LOAD: begin
                gate_in.mode  = new_mode;
                override_next = new_override;
                tvalid_next   = new_time_valid;
            end
            rgtc_pkg::FUNC_REEVAL: begin
                run_gate = 1'b1;
            end
            default: begin
                run_gate = 1'b0;
            end
        endcase
    end

    rgtc_gate u_gate (
        .st_in        (gate_in),
        .go           (motor_next | override_next),
        .timing_valid (tvalid_reg),
        .now_ms       (now_ms),
        .gate_out     (gate_res)
    );

    assign gst_next = run_gate ? gate_res.st : gate_in;

    // Advance state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_level_reg <= 1'b0;
            motor_reg     <= 1'b0;
            armed_reg     <= 1'b0;
            since_reg     <= '0;
            override_reg  <= 1'b0;
            tvalid_reg    <= 1'b0;
            gst_reg       <= '0;
        end else if (item_accept) begin
            deb_level_reg <= deb_level_next;
            motor_reg     <= motor_next;
            armed_reg     <= armed_next;
            since_reg     <= since_next;
            override_reg  <= override_next;
            tvalid_reg    <= tvalid_next;
            gst_reg       <= gst_next;
        end
    end

    // Assemble the result from the post-item state
    always_comb begin
        result                  = '0;
        result.remote_en        = motor_next;
        result.mode             = gst_next.mode;
        result.play_permit      = gst_next.play_permit;
        result.rec_permit       = gst_next.rec_permit;
        result.play_hold        = gst_next.play_hold;
        result.rec_hold         = gst_next.rec_hold;
        result.play_begun       = gst_next.play_begun;
        result.override_now     = override_next;
        result.played_ms        = gst_next.base_ms;
        result.segment_start_ms = gst_next.resume_ms;
        result.stop_rec_pulse   = run_gate & gate_res.stop_rec;
        result.refresh_pulse    = run_gate & gate_res.refresh;
    end

endmodule
`default_nettype wire

@@ rtl/core/rgtc_skid.sv @@
// Two-entry result buffer: output register plus a skid register.
`default_nettype none
module rgtc_skid (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire rgtc_pkg::result_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output rgtc_pkg::result_t  out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    rgtc_pkg::result_t out_data_reg;
    rgtc_pkg::result_t skid_data_reg;
    logic              in_fire;
    logic              out_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid & in_ready;
    assign out_free  = !out_valid_reg | out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control: refill the output stage from the skid first, else from the input
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_fire) begin
                out_data_reg <= in_data;
            end
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/remote_gated_transport_control.sv @@
// Top level of the remote-gated transport control.
`default_nettype none
// Each input transaction carries a function code in s_tuser (scan the active-low
// remote pin, force the remote level, load transport context, or re-evaluate) and
// returns exactly one result transaction. The pin is debounced against the s_tdata
// time stamp with separate on and off delays (config registers 0 and 1, reset 50
// and 500 ms); a remote change or re-evaluation runs the play/record gate, which
// sets permit and pause flags, accumulates paused play time and pulses
// stop-recording and display-refresh. Debounce and gate are a single combinational
// pass into the state registers, and a new transaction is accepted every cycle
// while the output buffer is not full. A two-entry output buffer lets one more
// transaction in while a result waits on m_tready. No clearing pass follows reset.
module remote_gated_transport_control (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: now_ms[31:0], pin_level[32], event_on[33], new_mode[36:34],
    //          new_override[37], new_time_valid[38], zero[39]
    input  wire logic [rgtc_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: func[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: remote_en[0], mode[3:1], play_permit[4], rec_permit[5], play_hold[6],
    //          rec_hold[7], play_begun[8], override_now[9], played_ms[41:10],
    //          segment_start_ms[73:42], stop_rec_pulse[74], refresh_pulse[75], zero[79:76]
    output logic [rgtc_pkg::M_TDATA_W-1:0] m_tdata
);

    rgtc_pkg::result_t result;
    rgtc_pkg::result_t out_result;
    logic              item_accept;

    assign item_accept = s_tvalid & s_tready;

    rgtc_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .item_accept    (item_accept),
        .func           (s_tuser),
        .now_ms         (s_tdata[31:0]),
        .pin_level      (s_tdata[32]),
        .event_on       (s_tdata[33]),
        .new_mode       (s_tdata[36:34]),
        .new_override   (s_tdata[37]),
        .new_time_valid (s_tdata[38]),
        .result         (result)
    );

    rgtc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = out_result;

endmodule
`default_nettype wire

@@ rtl/core/rgtc_checker.sv @@
// Port-level checker for the transport control, bound to the top level.
`default_nettype none
module rgtc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [rgtc_pkg::M_TDATA_W-1:0] m_tdata
);

    // No result straight out of reset
    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Permit and pause never both set for one side
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[4] && m_tdata[6]) && !(m_tdata[5] && m_tdata[7]))
        else $error("permit and hold both set");

    // A refresh pulse leaves the mode at play standby; a stop pulse keeps recording mode
    a_pulse_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[75] || m_tdata[3:1] == rgtc_pkg::MODE_PLAY_STBY) &&
                     (!m_tdata[74] || m_tdata[3:1] == rgtc_pkg::MODE_RECORDING))
        else $error("pulse with wrong mode");

endmodule

bind remote_gated_transport_control rgtc_checker u_rgtc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
